/* src/pls_pkg.sv */
// ----------------------------------------------------------------------------
// pls_pkg
// Shared types and constants for the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

	localparam int PLS_DEPTH  = 16;
	localparam int PLS_DATA_W = 32;

	// Fixed field widths on the streams
	localparam int POS_W      = 5;
	localparam int OUT_DATA_W = 32;
	localparam int IN_VALUE_W = 32;
	localparam int OP_W       = 2;
	localparam int COUNT_W    = 5;
	localparam int STATUS_W   = 2;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// Decision for one operation, from control to the entry array
	typedef struct packed {
		logic    ins;    // open a slot at the target and load the word
		logic    rem;    // close the slot at the target
		logic    take;   // the word at the target goes out as result data
		status_t status;
	} cmd_t;

endpackage

/* src/pls_ctrl.sv */
// ----------------------------------------------------------------------------
// pls_ctrl
// Entry count and per-operation decode: status, target index, next count.
// ----------------------------------------------------------------------------
module pls_ctrl import pls_pkg::*; #(
	parameter int DEPTH = PLS_DEPTH
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  logic [OP_W-1:0]              op,
	input  logic [POS_W-1:0]             position,
	output cmd_t                         cmd,
	output logic [$clog2(DEPTH)-1:0]     at,
	output logic [$clog2(DEPTH+1)-1:0]   cnt,
	output logic [$clog2(DEPTH+1)-1:0]   cnt_next
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0] cnt_q;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] at_x;
	logic             full;
	logic             empty;
	logic             below;

	assign cnt_x = CMP_W'(cnt_q);
	assign pos_x = CMP_W'(position);
	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign below = (pos_x < cnt_x);

	always_comb begin
		cmd        = '{ins: 1'b0, rem: 1'b0, take: 1'b0, status: ST_OK};
		at_x       = below ? pos_x : (cnt_x - CMP_W'(1));
		unique case (op)
			OP_INSERT: begin
				at_x = below ? pos_x : cnt_x;
				if (full) begin
					cmd.status = ST_FULL;
				end else begin
					cmd.ins = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else begin
					cmd.rem  = 1'b1;
					cmd.take = 1'b1;
				end
			end
			OP_READ: begin
				if (empty) begin
					cmd.status = ST_EMPTY;
				end else if (pos_x > cnt_x) begin
					cmd.status = ST_RANGE;
				end else begin
					cmd.take = 1'b1;
				end
			end
			default: begin
				// unused code: no change, no data
			end
		endcase
	end

	assign at  = at_x[IDX_W-1:0];
	assign cnt = cnt_q;

	always_comb begin
		cnt_next = cnt_q;
		if (cmd.ins) begin
			cnt_next = cnt_q + CNT_W'(1);
		end else if (cmd.rem) begin
			cnt_next = cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (adv) begin
			cnt_q <= cnt_next;
		end
	end

endmodule

/* src/pls_array.sv */
// ----------------------------------------------------------------------------
// pls_array
// Packed entry array; each slot shifts, holds or loads, all slots at once.
// ----------------------------------------------------------------------------
module pls_array import pls_pkg::*; #(
	parameter int DEPTH  = PLS_DEPTH,
	parameter int DATA_W = PLS_DATA_W
) (
	input  logic                     clk,
	input  logic                     adv,
	input  cmd_t                     cmd,
	input  logic [$clog2(DEPTH)-1:0] at,
	input  logic [DATA_W-1:0]        word,
	output logic [DATA_W-1:0]        rd_data
);

	localparam int IDX_W = $clog2(DEPTH);

	logic [DATA_W-1:0] entries_q [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		logic [DATA_W-1:0] prev;
		logic [DATA_W-1:0] next;

		if (i == 0) begin : g_first
			assign prev = entries_q[i];
		end else begin : g_mid
			assign prev = entries_q[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign next = entries_q[i];
		end else begin : g_body
			assign next = entries_q[i+1];
		end

		always_ff @(posedge clk) begin
			if (adv && cmd.ins) begin
				if (IDX_W'(i) > at) begin
					entries_q[i] <= prev;
				end else if (IDX_W'(i) == at) begin
					entries_q[i] <= word;
				end
			end else if (adv && cmd.rem) begin
				if (IDX_W'(i) >= at) begin
					entries_q[i] <= next;
				end
			end
		end
	end

	assign rd_data = entries_q[at];

endmodule

/* src/positional_list_store.sv */
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered store of up to DEPTH words with insert, remove and read by position.
// ----------------------------------------------------------------------------
// Each transaction on the input stream carries one operation: insert a word
// before a position (append when the position is at or past the count),
// remove the entry at a position (the last one when at or past the count), or
// read the entry at a position (a position equal to the count reads the last
// entry, one beyond it reports a range error). Every operation returns exactly
// one result transaction with the data word, a status and the entry count
// after the operation. The block takes one transaction per clock cycle when
// the result side keeps up. The input register comes first; then the decode
// and the whole entry array update happen together, every slot picking
// shift, hold or load at once, while the result register
// is loaded. A stalled result holds the block, with one more transaction
// parked in the input register.
module positional_list_store import pls_pkg::*; #(
	parameter int DEPTH  = PLS_DEPTH,
	parameter int DATA_W = PLS_DATA_W
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // op[1:0], position[6:2], value[38:7], zero[39]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // data[31:0], status[33:32], count[38:34], zero[39]
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CW_X  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int VW_X  = (DATA_W > IN_VALUE_W) ? DATA_W : IN_VALUE_W;
	localparam int DW_X  = (DATA_W > OUT_DATA_W) ? DATA_W : OUT_DATA_W;

	// Input register
	logic                  valid_s1;
	logic [OP_W-1:0]       op_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [IN_VALUE_W-1:0] value_s1;

	// Result register
	logic                  m_tvalid_q;
	logic [39:0]           m_tdata_q;

	logic                  adv;
	cmd_t                  cmd;
	logic [IDX_W-1:0]      at;
	logic [CNT_W-1:0]      cnt;
	logic [CNT_W-1:0]      cnt_next;
	logic [DATA_W-1:0]     rd_data;
	logic [VW_X-1:0]       value_x;
	logic [DW_X-1:0]       rd_x;
	logic [CW_X-1:0]       cnt_x;
	logic [OUT_DATA_W-1:0] data_out;

	// Advance when the result register is empty or being drained
	assign adv      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tdata[1:0];
			pos_s1   <= s_tdata[6:2];
			value_s1 <= s_tdata[38:7];
		end
	end

	pls_ctrl #(
		.DEPTH    (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.op       (op_s1),
		.position (pos_s1),
		.cmd      (cmd),
		.at       (at),
		.cnt      (cnt),
		.cnt_next (cnt_next)
	);

	// Keep the inserted word to DATA_W bits
	assign value_x = VW_X'(value_s1);

	pls_array #(
		.DEPTH   (DEPTH),
		.DATA_W  (DATA_W)
	) u_array (
		.clk     (clk),
		.adv     (adv),
		.cmd     (cmd),
		.at      (at),
		.word    (value_x[DATA_W-1:0]),
		.rd_data (rd_data)
	);

	// Drop data unless the operation returns a word
	assign rd_x     = DW_X'(rd_data);
	assign data_out = cmd.take ? rd_x[OUT_DATA_W-1:0] : '0;
	assign cnt_x    = CW_X'(cnt_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_tdata_q <= {1'b0, cnt_x[COUNT_W-1:0], cmd.status, data_out};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------

	// Count never exceeds the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt <= CNT_W'(DEPTH))
		else $error("entry count above capacity");

	// A full-store insert leaves the count as it was
	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd.status == ST_FULL |=> $stable(cnt))
		else $error("count changed on a full insert");

	// Any status other than ok carries zero data
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33:32] != ST_OK |-> m_tdata[31:0] == '0)
		else $error("nonzero data with error status");

	// A stalled result with a parked item blocks the input
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && m_tvalid_q && !m_tready |-> !s_tready)
		else $error("input taken while both stages are held");

endmodule
